@@ rtl/clx_pkg.sv @@
// ----------------------------------------------------------------------------
// clx_pkg
// Shared types, character codes and keyword table of the c-subset lexer.
// ----------------------------------------------------------------------------
package clx_pkg;

   localparam int WORD_BUFFER_CHARS_DEF = 8;
   localparam int LENGTH_BITS_DEF       = 16;

   localparam int NUM_KEYWORDS  = 13;
   localparam int KW_MAX_CHARS  = 6;
   localparam int QUEUE_DEPTH   = 4;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 40;
   localparam int RSP_USER_W    = 3;
   localparam int OUT_LEN_W     = 16;

   // keyword text, last character in the lowest byte
   localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      "int", "float", "double", "char", "if", "else", "while",
      "for", "return", "void", "main", "cout", "cin"
   };
   localparam int KW_LEN [NUM_KEYWORDS] = '{3, 5, 6, 4, 2, 4, 5, 3, 6, 4, 4, 4, 3};

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   typedef enum logic [2:0] {
      CLS_KEYWORD  = 3'd0,
      CLS_CONSTANT = 3'd1,
      CLS_IDENT    = 3'd2,
      CLS_STRING   = 3'd3,
      CLS_OPERATOR = 3'd4,
      CLS_SPECIAL  = 3'd5
   } token_class_type;

   typedef enum logic {
      ACT_CHAR  = 1'b0,
      ACT_FLUSH = 1'b1
   } action_type;

   typedef struct packed {
      token_class_type       cls;
      logic [3:0]            kw_idx;
      logic [OUT_LEN_W-1:0]  length;
      logic [7:0]            sym1;
      logic [7:0]            sym2;
   } token_type;

   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             is_digit(c) || (c == CH_DOT);
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      return (c == CH_EQ) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_GT);
   endfunction

   function automatic logic is_special_char(input logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
             (c == CH_RBRACE) || (c == CH_SEMI);
   endfunction

   function automatic token_type sym_token(input token_class_type cls,
                                           input logic [7:0] s1, input logic [7:0] s2);
      token_type t;
      t.cls    = cls;
      t.kw_idx = '0;
      t.length = '0;
      t.sym1   = s1;
      t.sym2   = s2;
      return t;
   endfunction

endpackage

@@ rtl/c_subset_lexer.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer
// Tokenizer for a small C subset, one source character per request.
//
//   channel | direction | tdata                 | tuser        | tlast
//   req_    | in        | char_code[7:0]        | action       | -
//   rsp_    | out       | kw, length, sym1/sym2 | token_class  | last_in_run
//
// one request per cycle while the queue is not full, decoded combinationally in the front part
// responses leave one per cycle while rsp_tready is high; a request with two tokens gives two
// the queue holds four entries; req_tready drops only when it is full
// reset clears the lexer state, apart from the word buffer, and empties the queue
// ----------------------------------------------------------------------------
module c_subset_lexer
   import clx_pkg::*;
#(
   parameter int WORD_BUFFER_CHARS = WORD_BUFFER_CHARS_DEF,
   parameter int LENGTH_BITS       = LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] char_code
   input  logic                  req_tuser,  // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] keyword_index, [19:4] token_length,
                                             // [27:20] symbol_first, [35:28] symbol_second
   output logic [RSP_USER_W-1:0] rsp_tuser,  // [2:0] token_class
   output logic                  rsp_tlast
);

   logic        q_full, q_push, q_pop;
   q_entry_type q_push_entry;
   q_head_type  q_head;

   clx_front #(
      .WORD_BUFFER_CHARS (WORD_BUFFER_CHARS),
      .LENGTH_BITS       (LENGTH_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   clx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   clx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/clx_front.sv @@
// ----------------------------------------------------------------------------
// clx_front
// Accepts characters, tracks word and string state, and builds the tokens
// that each request causes as one queue entry.
// ----------------------------------------------------------------------------
module clx_front
   import clx_pkg::*;
#(
   parameter int WORD_BUFFER_CHARS = WORD_BUFFER_CHARS_DEF,
   parameter int LENGTH_BITS       = LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output q_entry_type           q_push_entry
);

   logic                   in_string_ff, in_string_in;
   logic                   pending_ff, pending_in;
   logic [LENGTH_BITS-1:0] run_len_ff, run_len_in;
   logic [1:0]             dot_cnt_ff, dot_cnt_in;
   logic                   non_digit_ff, non_digit_in;
   logic [7:0]             wbuf_ff [WORD_BUFFER_CHARS];

   logic                   fire;
   logic [7:0]             c;
   logic                   buf_wr;
   logic                   kw_hit, kw_eq;
   logic [3:0]             kw_idx;
   logic [OUT_LEN_W-1:0]   len_sat;
   token_type              word_tok, tok_a, tok_b;
   logic                   a_valid, b_valid;
   logic                   run_full;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign run_full   = (run_len_ff == '1);

   // output length saturates at 16 bits
   always_comb begin
      if (32'(run_len_ff) > 32'd65535) begin
         len_sat = '1;
      end else begin
         len_sat = OUT_LEN_W'(32'(run_len_ff));
      end
   end

   // keyword match against the stored word
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      kw_eq  = 1'b0;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         kw_eq = (KW_LEN[k] <= WORD_BUFFER_CHARS) && (32'(run_len_ff) == 32'(KW_LEN[k]));
         for (int j = 0; j < KW_MAX_CHARS; j++) begin
            if (j < KW_LEN[k] && j < WORD_BUFFER_CHARS) begin
               if (wbuf_ff[j] != KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8]) begin
                  kw_eq = 1'b0;
               end
            end
         end
         if (!kw_hit && kw_eq) begin
            kw_hit = 1'b1;
            kw_idx = 4'(k);
         end
      end
   end

   always_comb begin
      word_tok.length = len_sat;
      word_tok.sym1   = '0;
      word_tok.sym2   = '0;
      if (kw_hit) begin
         word_tok.cls    = CLS_KEYWORD;
         word_tok.kw_idx = kw_idx;
      end else begin
         word_tok.kw_idx = '0;
         if (!non_digit_ff && dot_cnt_ff <= 2'd1) begin
            word_tok.cls = CLS_CONSTANT;
         end else begin
            word_tok.cls = CLS_IDENT;
         end
      end
   end

   always_comb begin
      in_string_in = in_string_ff;
      pending_in   = pending_ff;
      run_len_in   = run_len_ff;
      dot_cnt_in   = dot_cnt_ff;
      non_digit_in = non_digit_ff;
      buf_wr       = 1'b0;
      a_valid      = 1'b0;
      b_valid      = 1'b0;
      tok_a        = word_tok;
      tok_b        = sym_token(CLS_OPERATOR, c, 8'h00);

      if (req_tuser == ACT_FLUSH) begin
         if (pending_ff) begin
            a_valid = 1'b1;
            tok_a   = sym_token(CLS_OPERATOR, CH_LT, 8'h00);
         end else if (in_string_ff) begin
            a_valid     = 1'b1;
            tok_a       = word_tok;
            tok_a.cls   = CLS_STRING;
            tok_a.kw_idx = '0;
         end else begin
            a_valid = (run_len_ff != '0);
         end
         in_string_in = 1'b0;
         pending_in   = 1'b0;
         run_len_in   = '0;
         dot_cnt_in   = '0;
         non_digit_in = 1'b0;
      end else if (pending_ff && c == CH_LT) begin
         pending_in = 1'b0;
         a_valid    = 1'b1;
         tok_a      = sym_token(CLS_OPERATOR, CH_LT, CH_LT);
      end else if (in_string_ff) begin
         if (c == CH_QUOTE) begin
            a_valid      = 1'b1;
            tok_a.cls    = CLS_STRING;
            tok_a.kw_idx = '0;
            in_string_in = 1'b0;
            run_len_in   = '0;
         end else if (!run_full) begin
            run_len_in = run_len_ff + 1'b1;
         end
      end else begin
         // a pending less-than goes out first, no word can be open then
         if (pending_ff) begin
            pending_in = 1'b0;
            a_valid    = 1'b1;
            tok_a      = sym_token(CLS_OPERATOR, CH_LT, 8'h00);
         end
         if (is_word_char(c)) begin
            buf_wr = (32'(run_len_ff) < 32'(WORD_BUFFER_CHARS));
            if (!run_full) begin
               run_len_in = run_len_ff + 1'b1;
            end
            if (c == CH_DOT) begin
               if (dot_cnt_ff != 2'd2) begin
                  dot_cnt_in = dot_cnt_ff + 2'd1;
               end
            end else if (!is_digit(c)) begin
               non_digit_in = 1'b1;
            end
         end else begin
            if (!pending_ff) begin
               a_valid = (run_len_ff != '0);
            end
            run_len_in   = '0;
            dot_cnt_in   = '0;
            non_digit_in = 1'b0;
            if (c == CH_QUOTE) begin
               in_string_in = 1'b1;
            end else if (c == CH_LT) begin
               pending_in = 1'b1;
            end else if (is_op_char(c)) begin
               b_valid = 1'b1;
            end else if (is_special_char(c)) begin
               b_valid = 1'b1;
               tok_b   = sym_token(CLS_SPECIAL, c, 8'h00);
            end
         end
      end
   end

   always_comb begin
      q_push = fire && (a_valid || b_valid);
      q_push_entry.two  = a_valid && b_valid;
      q_push_entry.tok1 = tok_b;
      if (a_valid) begin
         q_push_entry.tok0 = tok_a;
      end else begin
         q_push_entry.tok0 = tok_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         pending_ff   <= 1'b0;
         run_len_ff   <= '0;
         dot_cnt_ff   <= '0;
         non_digit_ff <= 1'b0;
      end else if (fire) begin
         in_string_ff <= in_string_in;
         pending_ff   <= pending_in;
         run_len_ff   <= run_len_in;
         dot_cnt_ff   <= dot_cnt_in;
         non_digit_ff <= non_digit_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WORD_BUFFER_CHARS; i++) begin
         if (fire && buf_wr && 32'(run_len_ff) == 32'(i)) begin
            wbuf_ff[i] <= c;
         end
      end
   end

endmodule

@@ rtl/clx_queue.sv @@
// ----------------------------------------------------------------------------
// clx_queue
// Short queue of token entries between the front and back parts.
// ----------------------------------------------------------------------------
module clx_queue
   import clx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output q_head_type  head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/clx_back.sv @@
// ----------------------------------------------------------------------------
// clx_back
// Sends the one or two tokens of each queue entry on the response channel
// and marks the last one.
// ----------------------------------------------------------------------------
module clx_back
   import clx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  q_head_type            head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic      phase_ff, phase_in;
   logic      fire;
   token_type tok;

   assign tok        = phase_ff ? head.entry.tok1 : head.entry.tok0;
   assign rsp_tvalid = head.valid;
   assign rsp_tlast  = phase_ff || !head.entry.two;
   assign rsp_tuser  = tok.cls;
   assign rsp_tdata  = {4'b0000, tok.sym2, tok.sym1, tok.length, tok.kw_idx};
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && rsp_tlast;

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         phase_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/clx_checker.sv @@
// ----------------------------------------------------------------------------
// clx_checker
// Port-level checks of the c-subset lexer, bound to the top level.
// ----------------------------------------------------------------------------
module clx_checker
   import clx_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_word_no_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLS_KEYWORD || rsp_tuser == CLS_CONSTANT ||
      rsp_tuser == CLS_IDENT || rsp_tuser == CLS_STRING) |-> rsp_tdata[35:20] == 16'h0000)
      else $error("word or string token carries a symbol");

   a_symbol_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLS_OPERATOR || rsp_tuser == CLS_SPECIAL) |->
      rsp_tdata[19:0] == 20'h00000 && rsp_tdata[27:20] != 8'h00)
      else $error("symbol token with length or without symbol");

   a_kw_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != CLS_KEYWORD |-> rsp_tdata[3:0] == 4'h0)
      else $error("keyword index on a non-keyword token");

endmodule

bind c_subset_lexer clx_checker u_clx_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the c-subset lexer. A queue of source characters
// and end markers (directed cases, then random code-like text with noise)
// feeds a request driver with random gaps. Each accepted request runs through
// a bench-side tokenizer whose expected tokens are compared field by field
// with the responses, which are taken with random stalls and one long
// hold-off.
// ----------------------------------------------------------------------------
module tb;
   import clx_pkg::*;

   localparam int WORD_CHARS   = WORD_BUFFER_CHARS_DEF;
   localparam int RANDOM_ITEMS = 870;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      action_type act;
      logic [7:0] ch;
   } src_item_type;

   typedef struct {
      token_class_type cls;
      logic [3:0]      kw;
      logic [15:0]     len;
      logic [7:0]      s1;
      logic [7:0]      s2;
      logic            last;
   } token_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   src_item_type  source_text[$];
   token_rec_type expected_tokens[$];
   token_rec_type step_tokens[$];

   string kw_words [NUM_KEYWORDS] = '{
      "int", "float", "double", "char", "if", "else", "while",
      "for", "return", "void", "main", "cout", "cin"
   };
   string sym_chars = "=+-*/><(){};";

   // tokenizer state
   logic        in_str = 1'b0;
   logic        lt_pending = 1'b0;
   logic [7:0]  word_buf [WORD_CHARS];
   logic [15:0] run_len = '0;
   logic [1:0]  dots = '0;
   logic        non_digit = 1'b0;

   int          failures = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          held_once = 1'b0;
   int          tokens_seen = 0;
   int          idle_cycles = 0;
   logic [31:0] cycle_count = '0;

   c_subset_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- tokenizer
   function automatic void emit_token(token_class_type c, logic [3:0] k, logic [15:0] n,
                                      logic [7:0] a, logic [7:0] b);
      token_rec_type t;
      t.cls  = c;
      t.kw   = k;
      t.len  = n;
      t.s1   = a;
      t.s2   = b;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void clear_lexer();
      in_str     = 1'b0;
      lt_pending = 1'b0;
      run_len    = '0;
      dots       = '0;
      non_digit  = 1'b0;
   endfunction

   function automatic void close_word();
      int hit;
      bit same;
      hit = -1;
      if (run_len == 0) return;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (hit < 0 && run_len == kw_words[k].len() && kw_words[k].len() <= WORD_CHARS) begin
            same = 1'b1;
            for (int i = 0; i < kw_words[k].len(); i++)
               if (word_buf[i] != kw_words[k][i]) same = 1'b0;
            if (same) hit = k;
         end
      end
      if (hit >= 0)
         emit_token(CLS_KEYWORD, 4'(hit), run_len, 8'd0, 8'd0);
      else if (!non_digit && dots <= 1)
         emit_token(CLS_CONSTANT, 4'd0, run_len, 8'd0, 8'd0);
      else
         emit_token(CLS_IDENT, 4'd0, run_len, 8'd0, 8'd0);
      run_len   = '0;
      dots      = '0;
      non_digit = 1'b0;
   endfunction

   function automatic bit is_word_ch(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9") || c == ".";
   endfunction

   function automatic void lex_char(logic [7:0] c);
      if (in_str) begin
         if (c == "\"") begin
            emit_token(CLS_STRING, 4'd0, run_len, 8'd0, 8'd0);
            in_str  = 1'b0;
            run_len = '0;
         end else if (run_len != 16'hFFFF) begin
            run_len++;
         end
         return;
      end
      if (c == "\"") begin
         close_word();
         in_str  = 1'b1;
         run_len = '0;
         return;
      end
      if (is_word_ch(c)) begin
         if (run_len < WORD_CHARS) word_buf[run_len] = c;
         if (run_len != 16'hFFFF) run_len++;
         if (c == ".") begin
            if (dots < 2) dots++;
         end else if (c < "0" || c > "9") begin
            non_digit = 1'b1;
         end
         return;
      end
      close_word();
      if (c == "<")
         lt_pending = 1'b1;
      else if (c == "=" || c == "+" || c == "-" || c == "*" || c == "/" || c == ">")
         emit_token(CLS_OPERATOR, 4'd0, 16'd0, c, 8'd0);
      else if (c == "(" || c == ")" || c == "{" || c == "}" || c == ";")
         emit_token(CLS_SPECIAL, 4'd0, 16'd0, c, 8'd0);
   endfunction

   function automatic void lex_step(action_type act, logic [7:0] c);
      step_tokens.delete();
      if (act == ACT_FLUSH) begin
         if (lt_pending)
            emit_token(CLS_OPERATOR, 4'd0, 16'd0, "<", 8'd0);
         else if (in_str)
            emit_token(CLS_STRING, 4'd0, run_len, 8'd0, 8'd0);
         else
            close_word();
         clear_lexer();
      end else if (lt_pending) begin
         lt_pending = 1'b0;
         if (c == "<") begin
            emit_token(CLS_OPERATOR, 4'd0, 16'd0, "<", "<");
         end else begin
            emit_token(CLS_OPERATOR, 4'd0, 16'd0, "<", 8'd0);
            lex_char(c);
         end
      end else begin
         lex_char(c);
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void push_char(logic [7:0] c);
      src_item_type s;
      s.act = ACT_CHAR;
      s.ch  = c;
      source_text.push_back(s);
   endfunction

   function automatic void push_text(string w);
      for (int i = 0; i < w.len(); i++) push_char(w[i]);
   endfunction

   function automatic void push_flush();
      src_item_type s;
      s.act = ACT_FLUSH;
      s.ch  = 8'($urandom_range(0, 255));
      source_text.push_back(s);
   endfunction

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0: return 8'("A" + $urandom_range(0, 25));
         1: return 8'("a" + $urandom_range(0, 25));
         2: return 8'("0" + $urandom_range(0, 9));
         default: return ".";
      endcase
   endfunction

   function automatic logic [7:0] string_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == "\"") c = 8'h21;
      return c;
   endfunction

   function automatic void add_fragment();
      int pick;
      int n;
      string w;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         w = kw_words[$urandom_range(0, NUM_KEYWORDS - 1)];
         if ($urandom_range(0, 4) == 0) w = {w, "x"};
         push_text(w);
      end else if (pick < 34) begin
         n = $urandom_range(1, 12);
         repeat (n) push_char(word_char());
      end else if (pick < 46) begin
         n = $urandom_range(1, 6);
         repeat (n) push_char(($urandom_range(0, 6) == 0) ? 8'(".")
                                                          : 8'("0" + $urandom_range(0, 9)));
      end else if (pick < 56) begin
         push_char("\"");
         n = $urandom_range(0, 8);
         repeat (n) push_char(string_char());
         if ($urandom_range(0, 7) != 0) push_char("\"");
      end else if (pick < 76) begin
         if ($urandom_range(0, 4) == 0) push_text("<<");
         else push_char(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
      end else if (pick < 86) begin
         push_char(($urandom_range(0, 3) == 0) ? 8'h0A : 8'(" "));
      end else if (pick < 96) begin
         push_char(8'($urandom_range(0, 255)));
      end else begin
         push_flush();
      end
      if ($urandom_range(0, 1) == 0) push_char(" ");
   endfunction

   function automatic int idle_len();
      if (cycle_count[9:8] == 2'd0) return 0;
      if ($urandom_range(0, 99) < 70) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         failures++;
      end
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      src_item_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) lex_step(action_type'(req_tuser), req_tdata);
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (source_text.size() > 0) begin
            s = source_text.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= s.ch;
            req_tuser  <= s.act;
            gap_left = idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      token_rec_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               $error("unexpected token, class %0d", rsp_tuser);
               failures++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_class", 16'(want.cls), 16'(rsp_tuser));
               check_field("keyword_index", 16'(want.kw), 16'(rsp_tdata[3:0]));
               check_field("token_length", want.len, rsp_tdata[19:4]);
               check_field("symbol_first", 16'(want.s1), 16'(rsp_tdata[27:20]));
               check_field("symbol_second", 16'(want.s2), 16'(rsp_tdata[35:28]));
               check_field("last_in_run", 16'(want.last), 16'(rsp_tlast));
            end
         end
         // one long hold-off so the request side backs up
         if (!held_once && tokens_seen >= 40) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = idle_len();
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int base;
      foreach (word_buf[i]) word_buf[i] = 8'd0;

      // keyword, shift operator, word cut by a quote, string
      push_text("cin<<q\"a\"");
      push_char(8'h00);
      push_char(8'hFF);
      // two dots make an identifier, then a lone less-than before a paren
      push_text("1..<(");
      push_text("+-*/=>");
      // end marker with a pending less-than, with an open string, then idle
      push_char("<");
      push_flush();
      push_text("\"x");
      push_flush();
      push_text(".;");
      push_flush();

      base = source_text.size();
      while (source_text.size() - base < RANDOM_ITEMS) add_fragment();
      push_flush();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      while (source_text.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && expected_tokens.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
